// ----- design/pots_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pots_pkg;

    // Page geometry: bytes per page and the matching shift.
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    // Field widths.
    localparam int ADDR_W   = 64;
    localparam int OWNER_W  = 31;
    localparam int RPAGES_W = 13;
    localparam int RUN_W    = 25;
    localparam int PN_W     = ADDR_W - PAGE_SHIFT;

    // Opcodes.
    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TEST = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INVAL = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Configuration register indexes.
    localparam logic REG_BASE  = 1'b0;
    localparam logic REG_PAGES = 1'b1;

    // Request word.
    typedef struct packed {
        logic               opcode;
        logic [ADDR_W-1:0]  addr;
        logic [ADDR_W-1:0]  length;
        logic [OWNER_W-1:0] owner;
    } req_t;

    // Result word.
    typedef struct packed {
        logic [1:0]       status;
        logic [RUN_W-1:0] run_bytes;
    } rsp_t;

endpackage

`default_nettype wire

// ----- design/page_owner_table_set_test.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                  Direction  Accepted when
// request   start, busy, request                     in         start && !busy
// result    done, result                             out        every cycle done is high
// config    cfg_valid, cfg_ready, cfg_index, cfg_data in         cfg_valid && cfg_ready
//
// After reset the owner table is cleared one entry per cycle, with busy high; configuration
// writes are taken during that pass. A request runs the checks S_PRE, S_SPAN, S_REND, S_LOW,
// S_HIGH and S_TAB, all but S_PRE on one shared 65-bit adder, then walks the table one page
// per cycle; a test stops at the first mismatch, and a rejected request ends early. The
// result word shows for one cycle on done, as busy falls; the receiver cannot stall it.
module page_owner_table_set_test #(
    parameter int PAGE_COUNT = 4096
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire pots_pkg::req_t request,
    output logic               done,
    output pots_pkg::rsp_t     result,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic          cfg_index,
    input  wire logic [63:0]   cfg_data
);

    import pots_pkg::*;

    localparam int IDX_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int CNT_W = $clog2(PAGE_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAGE_COUNT - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PRE,
        S_SPAN,
        S_REND,
        S_LOW,
        S_HIGH,
        S_TAB,
        S_SET,
        S_TEST
    } state_t;

    state_t state_reg, state_next;

    // Control and result registers.
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    issue_left_reg, issue_left_next;
    logic [CNT_W-1:0]    cmp_left_reg, cmp_left_next;
    logic [CNT_W-1:0]    run_reg, run_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                done_reg, done_next;
    rsp_t                result_reg, result_next;
    logic [ADDR_W-1:0]   region_base_reg;
    logic [RPAGES_W-1:0] region_pages_reg;

    // Payload registers.
    req_t                req_reg;
    logic [PN_W-1:0]     pages_reg, pages_next;
    logic [ADDR_W-1:0]   span_end_reg, region_end_reg, offset_reg;

    // Memory port.
    logic [OWNER_W-1:0]  mem [PAGE_COUNT];
    logic                mem_we;
    logic [OWNER_W-1:0]  mem_wdata;
    logic [OWNER_W-1:0]  rd_data_reg;

    // Shared adder.
    logic [ADDR_W-1:0]   add_a, add_b;
    logic                add_cin;
    logic [ADDR_W:0]     sum;

    logic                accept;
    logic                len_ovf;
    logic [PN_W-1:0]     pages_calc;
    logic [ADDR_W-1:0]   rounded;
    logic [ADDR_W-1:0]   region_size;
    logic                fin;
    logic [1:0]          fin_status;
    logic [CNT_W-1:0]    fin_run;
    logic                issue;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    // Page rounding of the request length.
    assign len_ovf     = (&req_reg.length[ADDR_W-1:PAGE_SHIFT])
                         && (|req_reg.length[PAGE_SHIFT-1:0]);
    assign pages_calc  = req_reg.length[ADDR_W-1:PAGE_SHIFT]
                         + PN_W'(|req_reg.length[PAGE_SHIFT-1:0]);
    assign rounded     = {pages_reg, {PAGE_SHIFT{1'b0}}};
    assign region_size = ADDR_W'(region_pages_reg) << PAGE_SHIFT;

    // Operand selection for the shared adder; subtraction by inverted operand.
    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        case (state_reg)
            S_SPAN:
            begin
                add_a = req_reg.addr;
                add_b = rounded;
            end
            S_REND:
            begin
                add_a = region_base_reg;
                add_b = region_size;
            end
            S_LOW:
            begin
                add_a   = req_reg.addr;
                add_b   = ~region_base_reg;
                add_cin = 1'b1;
            end
            S_HIGH:
            begin
                add_a   = region_end_reg;
                add_b   = ~span_end_reg;
                add_cin = 1'b1;
            end
            S_TAB:
            begin
                add_a = ADDR_W'(offset_reg[ADDR_W-1:PAGE_SHIFT]);
                add_b = ADDR_W'(pages_reg);
            end
            default:
            begin
                add_a = '0;
            end
        endcase
    end

    assign sum = {1'b0, add_a} + {1'b0, add_b} + (ADDR_W + 1)'(add_cin);

    assign issue = (issue_left_reg != '0);

    // Sequencer next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        issue_left_next = issue_left_reg;
        cmp_left_next   = cmp_left_reg;
        run_next        = run_reg;
        rd_pend_next    = 1'b0;
        pages_next      = pages_reg;
        fin             = 1'b0;
        fin_status      = ST_OK;
        fin_run         = '0;
        mem_we          = 1'b0;
        mem_wdata       = '0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                pages_next = pages_calc;
                if (req_reg.addr == '0 || req_reg.addr[PAGE_SHIFT-1:0] != '0)
                begin
                    fin        = 1'b1;
                    fin_status = ST_INVAL;
                end
                else if (len_ovf)
                begin
                    fin        = 1'b1;
                    fin_status = ST_RANGE;
                end
                else if (req_reg.length == '0)
                begin
                    fin        = 1'b1;
                    fin_status = ST_INVAL;
                end
                else
                begin
                    state_next = S_SPAN;
                end
            end
            S_SPAN:
            begin
                if (sum[ADDR_W])
                begin
                    fin        = 1'b1;
                    fin_status = ST_RANGE;
                end
                else
                begin
                    state_next = S_REND;
                end
            end
            S_REND:
            begin
                if (sum[ADDR_W])
                begin
                    fin        = 1'b1;
                    fin_status = ST_RANGE;
                end
                else
                begin
                    state_next = S_LOW;
                end
            end
            S_LOW:
            begin
                // No carry out means the address lies below the region base.
                if (!sum[ADDR_W])
                begin
                    fin        = 1'b1;
                    fin_status = ST_INVAL;
                end
                else
                begin
                    state_next = S_HIGH;
                end
            end
            S_HIGH:
            begin
                // No carry out means the span ends past the region end.
                if (!sum[ADDR_W])
                begin
                    fin        = 1'b1;
                    fin_status = ST_INVAL;
                end
                else
                begin
                    state_next = S_TAB;
                end
            end
            S_TAB:
            begin
                idx_next        = offset_reg[PAGE_SHIFT +: IDX_W];
                issue_left_next = pages_reg[CNT_W-1:0];
                cmp_left_next   = pages_reg[CNT_W-1:0];
                run_next        = '0;
                if (sum > (ADDR_W + 1)'(PAGE_COUNT))
                begin
                    fin        = 1'b1;
                    fin_status = ST_RANGE;
                end
                else if (req_reg.opcode == OP_SET)
                begin
                    state_next = S_SET;
                end
                else
                begin
                    state_next = S_TEST;
                end
            end
            S_SET:
            begin
                mem_we          = 1'b1;
                mem_wdata       = req_reg.owner;
                idx_next        = idx_reg + 1'b1;
                issue_left_next = issue_left_reg - 1'b1;
                if (issue_left_reg == CNT_W'(1))
                begin
                    fin = 1'b1;
                end
            end
            S_TEST:
            begin
                // Reads are issued every cycle while pages remain; each compare follows in the next cycle.
                if (issue)
                begin
                    idx_next        = idx_reg + 1'b1;
                    issue_left_next = issue_left_reg - 1'b1;
                end
                rd_pend_next = issue;
                if (rd_pend_reg)
                begin
                    if (rd_data_reg == req_reg.owner)
                    begin
                        run_next      = run_reg + 1'b1;
                        cmp_left_next = cmp_left_reg - 1'b1;
                        if (cmp_left_reg == CNT_W'(1))
                        begin
                            fin     = 1'b1;
                            fin_run = run_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        fin     = 1'b1;
                        fin_run = run_reg;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (fin)
        begin
            state_next = S_IDLE;
        end
    end

    assign done_next             = fin;
    assign result_next.status    = fin_status;
    assign result_next.run_bytes = RUN_W'(fin_run) << PAGE_SHIFT;

    // State, control and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            idx_reg          <= '0;
            issue_left_reg   <= '0;
            cmp_left_reg     <= '0;
            run_reg          <= '0;
            rd_pend_reg      <= 1'b0;
            done_reg         <= 1'b0;
            result_reg       <= '0;
            region_base_reg  <= '0;
            region_pages_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            issue_left_reg <= issue_left_next;
            cmp_left_reg   <= cmp_left_next;
            run_reg        <= run_next;
            rd_pend_reg    <= rd_pend_next;
            done_reg       <= done_next;
            result_reg     <= result_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_BASE)
                begin
                    region_base_reg <= cfg_data;
                end
                else
                begin
                    region_pages_reg <= cfg_data[RPAGES_W-1:0];
                end
            end
        end
    end

    // Request word and intermediate sums from the shared adder.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        pages_reg <= pages_next;
        if (state_reg == S_SPAN)
        begin
            span_end_reg <= sum[ADDR_W-1:0];
        end
        if (state_reg == S_REND)
        begin
            region_end_reg <= sum[ADDR_W-1:0];
        end
        if (state_reg == S_LOW)
        begin
            offset_reg <= sum[ADDR_W-1:0];
        end
    end

    // Owner table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= mem_wdata;
        end
        rd_data_reg <= mem[idx_reg];
    end

`ifndef ASSERT_OFF
    // The result strobe lasts a single cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // An accepted request makes the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("block not busy after accepting a request");

    // Rejected requests report no run length (set requests report none either, but are not checked here).
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |-> result.run_bytes == '0)
        else $error("rejected request carries a run length");

    // The table is never written while the block waits for a request.
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !mem_we)
        else $error("table written while idle");

    // The strobe only shows once the sequencer is back in idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE)
        else $error("result shown while sequencer still working");
`endif

endmodule

`default_nettype wire
